@@ hdl/imc7_pkg.sv @@
// Shared types and codes for the IMAP modified UTF-7 to UTF-8 decoder.
// No dependencies; imported by the decode, output buffer, checker and top-level files.
`default_nettype none

package imc7_pkg;

    // Sticky per-string error code, reported in the status field.
    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_EMPTY_RUN     = 3'd1,
        ST_PAD_BITS      = 3'd2,
        ST_ODD_BYTES     = 3'd3,
        ST_HIGH_UNPAIRED = 3'd4,
        ST_LOW_LONE      = 3'd5
    } status_t;

    // Decoder state carried from one input word to the next.
    typedef struct packed {
        logic       in_run;
        logic       run_empty;
        logic [5:0] bit_buffer;
        logic [2:0] bit_total;
        logic       half_valid;
        logic [7:0] half_unit;
        logic       hs_valid;
        logic [9:0] hs_bits;
        status_t    err;
    } imc7_state_t;

    // Everything one input word produces: up to four result words.
    typedef struct packed {
        logic [3:0][7:0] bytes;      // bytes[0] goes out first
        logic [2:0]      count;      // number of result words, 0 to 4
        logic            data_flag;  // 0 for a status-only word
        logic            done;       // last word closes the string
        status_t         status;
    } imc7_result_t;

endpackage

`default_nettype wire

@@ hdl/imap_mutf7_to_utf8_decoder_unit.sv @@
// Top level of the IMAP modified UTF-7 to UTF-8 decoder: input register,
// decode step, state register and output buffer. Depends on imc7_pkg,
// imc7_decode and imc7_out_buf.
//
//   side    ports     tdata          tuser                   tlast
//   slave   s_*       [7:0] in_char  -                       end_of_string
//   master  m_*       [7:0] out_byte [0] byte_valid [3:1] st string_done
//
// One character enters per cycle while the output buffer can take its words; it
// is decoded in the cycle after it is registered. A character yielding more than
// one word holds the next character in the input register while the output buffer
// drains. Characters producing no word never wait on the master.
// Synchronous active-low reset clears the state, the input and output valids.
`default_nettype none

module imap_mutf7_to_utf8_decoder_unit
    import imc7_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_char
    input  wire logic       s_tlast,   // end_of_string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // string_done
    output logic [3:0]      m_tuser    // [0] byte_valid, [3:1] status
);

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_eos_reg;
    imc7_state_t  state_reg, state_next;
    imc7_result_t result;
    logic         buf_free;
    logic         advance;

    imc7_decode u_decode (
        .in_char    (in_char_reg),
        .eos        (in_eos_reg),
        .state_i    (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // commit a word once its results fit in the output buffer
    assign advance  = in_valid_reg && (result.count == 3'd0 || buf_free);
    assign s_tready = !in_valid_reg || advance;

    imc7_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && result.count != 3'd0),
        .load_data (result),
        .free      (buf_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance)  state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

endmodule

`default_nettype wire

@@ hdl/imc7_decode.sv @@
// Combinational step of the decoder: one character plus current state gives
// the next state and up to four UTF-8 bytes. Depends on imc7_pkg.
`default_nettype none

module imc7_decode
    import imc7_pkg::*;
(
    input  wire logic [7:0]  in_char,
    input  wire logic        eos,
    input  imc7_state_t      state_i,
    output imc7_state_t      state_next,
    output imc7_result_t     result
);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_DASH = 8'h2d;

    // {valid, sextet value} of one base64 character, ',' alphabet
    function automatic logic [6:0] b64_dec(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5a)      r = {1'b1, 6'(c - 8'd65)};
        else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, 6'(c - 8'd71)};
        else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c + 8'd4)};
        else if (c == 8'h2b)               r = {1'b1, 6'd62};
        else if (c == 8'h2c)               r = {1'b1, 6'd63};
        return r;
    endfunction

    // Error raised when a run closes; an earlier error wins.
    function automatic status_t close_err(input imc7_state_t s);
        status_t e;
        e = s.err;
        if (s.err == ST_OK) begin
            if (s.run_empty)              e = ST_EMPTY_RUN;
            else if (s.bit_buffer != '0)  e = ST_PAD_BITS;
            else if (s.half_valid)        e = ST_ODD_BYTES;
            else if (s.hs_valid)          e = ST_HIGH_UNPAIRED;
        end
        return e;
    endfunction

    function automatic imc7_state_t clear_run(input imc7_state_t s);
        imc7_state_t r;
        r = '0;
        r.err = s.err;
        return r;
    endfunction

    always_comb begin
        imc7_state_t     st;
        logic [3:0][7:0] pb;
        logic [2:0]      pn;
        logic [6:0]      sx;
        logic [11:0]     acc;
        logic [2:0]      tot;
        logic [7:0]      byte_v;
        logic [15:0]     unit;
        logic [20:0]     cp;
        logic            plain;

        st     = state_i;
        pb     = '0;
        pn     = '0;
        sx     = b64_dec(in_char);
        acc    = '0;
        tot    = '0;
        byte_v = '0;
        unit   = '0;
        cp     = '0;
        plain  = 1'b0;

        if (st.in_run) begin
            if (sx[6]) begin
                st.run_empty = 1'b0;
                acc = {st.bit_buffer, sx[5:0]};
                if (st.bit_total >= 3'd2) begin
                    tot    = st.bit_total - 3'd2;
                    byte_v = 8'(acc >> tot);
                    acc    = acc & ((12'd1 << tot) - 12'd1);
                    st.bit_buffer = acc[5:0];
                    st.bit_total  = tot;
                    if (!st.half_valid) begin
                        st.half_unit  = byte_v;
                        st.half_valid = 1'b1;
                    end else begin
                        st.half_valid = 1'b0;
                        unit = {st.half_unit, byte_v};
                        if (st.hs_valid) begin
                            st.hs_valid = 1'b0;
                            if (unit[15:10] == 6'b110111) begin
                                cp = 21'h10000 + 21'({st.hs_bits, unit[9:0]});
                                pb[0] = {5'b11110, cp[20:18]};
                                pb[1] = {2'b10, cp[17:12]};
                                pb[2] = {2'b10, cp[11:6]};
                                pb[3] = {2'b10, cp[5:0]};
                                pn = 3'd4;
                            end else if (st.err == ST_OK) begin
                                st.err = ST_HIGH_UNPAIRED;
                            end
                        end else if (unit[15:10] == 6'b110110) begin
                            st.hs_valid = 1'b1;
                            st.hs_bits  = unit[9:0];
                        end else if (unit[15:10] == 6'b110111) begin
                            if (st.err == ST_OK) st.err = ST_LOW_LONE;
                        end else if (unit <= 16'h007f) begin
                            pb[0] = unit[7:0];
                            pn = 3'd1;
                        end else if (unit <= 16'h07ff) begin
                            pb[0] = {3'b110, unit[10:6]};
                            pb[1] = {2'b10, unit[5:0]};
                            pn = 3'd2;
                        end else begin
                            pb[0] = {4'b1110, unit[15:12]};
                            pb[1] = {2'b10, unit[11:6]};
                            pb[2] = {2'b10, unit[5:0]};
                            pn = 3'd3;
                        end
                    end
                end else begin
                    st.bit_buffer = acc[5:0];
                    st.bit_total  = st.bit_total + 3'd6;
                end
            end else if (st.run_empty && in_char == CH_DASH) begin
                pb[0] = CH_AMP;
                pn = 3'd1;
                st = clear_run(st);
            end else begin
                st.err = close_err(st);
                st = clear_run(st);
                plain = (in_char != CH_DASH);
            end
        end else begin
            plain = 1'b1;
        end

        if (plain) begin
            if (in_char == CH_AMP) begin
                st = clear_run(st);
                st.in_run    = 1'b1;
                st.run_empty = 1'b1;
            end else begin
                pb[0] = in_char;
                pn = 3'd1;
            end
        end

        // drop data once the string has an error
        if (st.err != ST_OK) begin
            pb = '0;
            pn = '0;
        end

        if (eos && st.in_run) begin
            st.err = close_err(st);
            st = clear_run(st);
        end

        result.bytes     = pb;
        result.done      = eos;
        result.status    = st.err;
        result.data_flag = (pn != '0);
        result.count     = (eos && pn == '0) ? 3'd1 : pn;

        state_next = eos ? imc7_state_t'('0) : st;
    end

endmodule

`default_nettype wire

@@ hdl/imc7_out_buf.sv @@
// Output register bank: holds the words of one decoded character and
// presents them one per handshake on the master side. Depends on imc7_pkg.
`default_nettype none

module imc7_out_buf
    import imc7_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  imc7_result_t     load_data,
    output logic             free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast,   // string_done
    output logic [3:0]       m_tuser    // [0] byte_valid, [3:1] status
);

    logic [3:0][7:0] bytes_reg;
    logic [2:0]      left_reg, left_next;
    logic [1:0]      idx_reg, idx_next;
    logic            done_reg;
    logic            flag_reg;
    status_t         status_reg;
    logic            take;

    assign take     = m_tvalid && m_tready;
    assign free     = (left_reg == 3'd0) || (left_reg == 3'd1 && m_tready);
    assign m_tvalid = (left_reg != 3'd0);
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tlast  = done_reg && (left_reg == 3'd1);
    assign m_tuser  = {status_reg, flag_reg};

    always_comb begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (load) begin
            left_next = load_data.count;
            idx_next  = '0;
        end else if (take) begin
            left_next = left_reg - 3'd1;
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            idx_reg  <= '0;
        end else begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg  <= load_data.bytes;
            done_reg   <= load_data.done;
            flag_reg   <= load_data.data_flag;
            status_reg <= load_data.status;
        end
    end

endmodule

`default_nettype wire

@@ hdl/imc7_checker.sv @@
// Port-level checks for the decoder top level, bound to every instance.
// Depends on imc7_pkg and imap_mutf7_to_utf8_decoder_unit.
`default_nettype none

module imc7_checker
    import imc7_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [3:0] m_tuser
);

    // hold a stalled word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("master word changed while stalled");

    // a status-only word exists only to close a string
    a_status_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("status-only word without string end");

    // a status-only word never carries a byte
    a_status_only_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
        else $error("status-only word with nonzero data");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind imap_mutf7_to_utf8_decoder_unit imc7_checker u_imc7_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
